@@ design/spa_pkg.sv @@
// Shared types, codes and bit-scan helpers for the slot pool allocator.
package spa_pkg;

    localparam int SLOT_W = 10;
    localparam int TOP_W  = 11;
    localparam int CAP_W  = 11;
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDERED_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_POP,
        S_REL,
        S_TRIM_RD,
        S_TRIM
    } t_state;

    typedef struct packed {
        logic [BIT_W:0]    run;
        logic [WORD_W-1:0] word;
    } t_trim;

    function automatic logic [BIT_W-1:0] f_lowest(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    // Clear the run of set bits from position b downwards and give its length.
    function automatic t_trim f_trim(input logic [WORD_W-1:0] w, input logic [BIT_W-1:0] b);
        logic [BIT_W-1:0] hz;
        logic             found;
        t_trim            r;
        hz    = '0;
        found = 1'b0;
        for (int i = 0; i < WORD_W; i++) begin
            if (i <= int'(b) && !w[i]) begin
                hz    = BIT_W'(i);
                found = 1'b1;
            end
        end
        r.word = w;
        for (int i = 0; i < WORD_W; i++) begin
            if (i <= int'(b) && (!found || i > int'(hz))) begin
                r.word[i] = 1'b0;
            end
        end
        r.run = found ? ({1'b0, b} - {1'b0, hz}) : ({1'b0, b} + (BIT_W + 1)'(1));
        return r;
    endfunction

endpackage

@@ design/spa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module spa_ram #(
    parameter int W = 32,
    parameter int D = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/slot_pool_allocator.sv @@
// Slot pool allocator top level: lowest-free-first marks or LIFO reuse, with a high-water mark.
// Sequence: bump allocate and plain release give a registered result straight from S_IDLE;
//   LIFO allocate goes via S_POP; ordered allocate via S_SCAN over the summary chunks (1 at
//   1024 slots) and S_TAKE; ordered release via S_REL, with S_TRIM_RD, S_TRIM per trimmed word.
// Throughput: one item at a time while busy is high; the mark RAM read-modify-write sets the pace.
// Reset: synchronous, clears top, counts and the word summary; no clearing pass, a mark word is
//   zeroed as the top enters it. Each result strobes for one cycle; the receiver cannot stall.
module slot_pool_allocator
    import spa_pkg::*;
#(
    parameter int POOL_SLOTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CAP_W-1:0]     i_cfg_data,
    output logic                 o_result_valid,
    output logic [SLOT_W-1:0]    o_granted_slot,
    output logic                 o_status,
    output logic [TOP_W-1:0]     o_top_count
);

    localparam int WW   = ($clog2(POOL_SLOTS + 1) > TOP_W) ? $clog2(POOL_SLOTS + 1) : TOP_W;
    localparam int NW   = (POOL_SLOTS + WORD_W - 1) / WORD_W;
    localparam int NWA  = (NW > 1) ? $clog2(NW) : 1;
    localparam int NCH  = (NW + WORD_W - 1) / WORD_W;
    localparam int NCA  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SUMW = NCA + BIT_W;
    localparam int SA   = $clog2(POOL_SLOTS);

    t_state                r_state, n_state;
    logic                  r_ordered;
    logic [CAP_W-1:0]      r_capacity;
    logic [WW-1:0]         r_top, n_top;
    logic [WW-1:0]         r_free_cnt, n_free_cnt;
    logic [WW-1:0]         r_depth, n_depth;
    logic [2**SUMW-1:0]    r_sum, n_sum;
    logic [NCA-1:0]        r_chunk, n_chunk;
    logic [NWA-1:0]        r_waddr, n_waddr;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic                  r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic                  r_out_status, n_out_status;
    logic [TOP_W-1:0]      r_out_top, n_out_top;

    logic                  mark_we;
    logic [NWA-1:0]        mark_waddr, mark_raddr;
    logic [WORD_W-1:0]     mark_wdata, mark_rdata;
    logic                  stk_we;
    logic [SA-1:0]         stk_waddr, stk_raddr;
    logic [SLOT_W-1:0]     stk_rdata;

    logic [WW-1:0]         usable;
    logic                  bump_ok;
    logic [WW-1:0]         top_dec;
    logic [WORD_W-1:0]     sum_chunk;
    logic [BIT_W-1:0]      take_bit;
    logic [BIT_W-1:0]      rel_bit;
    logic [BIT_W-1:0]      trim_bit;
    t_trim                 trim;
    logic                  do_bump;
    logic                  emit;

    spa_ram #(.W(WORD_W), .D(NW)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    spa_ram #(.W(SLOT_W), .D(POOL_SLOTS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (i_slot),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign usable    = (WW'(r_capacity) < WW'(POOL_SLOTS)) ? WW'(r_capacity) : WW'(POOL_SLOTS);
    assign bump_ok   = r_top < usable;
    assign top_dec   = r_top - WW'(1);
    assign sum_chunk = r_sum[{r_chunk, {BIT_W{1'b0}}} +: WORD_W];
    assign take_bit  = f_lowest(mark_rdata);
    assign rel_bit   = r_slot[BIT_W-1:0];
    assign trim_bit  = top_dec[BIT_W-1:0];
    assign trim      = f_trim(mark_rdata, trim_bit);

    always_comb begin
        n_state      = r_state;
        n_top        = r_top;
        n_free_cnt   = r_free_cnt;
        n_depth      = r_depth;
        n_sum        = r_sum;
        n_chunk      = r_chunk;
        n_waddr      = r_waddr;
        n_slot       = r_slot;
        n_out_valid  = 1'b0;
        n_out_slot   = '0;
        n_out_status = ST_OK;
        n_out_top    = r_out_top;
        mark_we      = 1'b0;
        mark_waddr   = r_waddr;
        mark_wdata   = '0;
        mark_raddr   = r_waddr;
        stk_we       = 1'b0;
        stk_waddr    = r_depth[SA-1:0];
        stk_raddr    = SA'(r_depth - WW'(1));
        do_bump      = 1'b0;
        emit         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_ALLOC) begin
                        if (r_ordered && r_free_cnt != '0) begin
                            n_chunk = '0;
                            n_state = S_SCAN;
                        end else if (!r_ordered && r_depth != '0) begin
                            n_depth = r_depth - WW'(1);
                            n_state = S_POP;
                        end else begin
                            do_bump = 1'b1;
                        end
                    end else begin
                        if (WW'(i_slot) >= r_top) begin
                            emit = 1'b1;
                        end else if (r_ordered) begin
                            mark_raddr = NWA'(i_slot >> BIT_W);
                            n_waddr    = NWA'(i_slot >> BIT_W);
                            n_slot     = i_slot;
                            n_state    = S_REL;
                        end else begin
                            if (r_depth < WW'(POOL_SLOTS)) begin
                                stk_we  = 1'b1;
                                n_depth = r_depth + WW'(1);
                            end
                            emit = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (sum_chunk != '0) begin
                    mark_raddr = NWA'({r_chunk, f_lowest(sum_chunk)});
                    n_waddr    = NWA'({r_chunk, f_lowest(sum_chunk)});
                    n_state    = S_TAKE;
                end else if (r_chunk == NCA'(NCH - 1)) begin
                    n_free_cnt = '0;
                    do_bump    = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_chunk = r_chunk + NCA'(1);
                end
            end
            S_TAKE: begin
                mark_we                = 1'b1;
                mark_wdata             = mark_rdata & ~(WORD_W'(1) << take_bit);
                n_sum[SUMW'(r_waddr)]  = |mark_wdata;
                n_free_cnt             = r_free_cnt - WW'(1);
                n_out_slot             = SLOT_W'({r_waddr, take_bit});
                emit                   = 1'b1;
                n_state                = S_IDLE;
            end
            S_POP: begin
                n_out_slot = stk_rdata;
                emit       = 1'b1;
                n_state    = S_IDLE;
            end
            S_REL: begin
                if (mark_rdata[rel_bit]) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else if (WW'(r_slot) == top_dec) begin
                    n_top = top_dec;
                    if (top_dec == '0) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_TRIM_RD;
                    end
                end else begin
                    mark_we               = 1'b1;
                    mark_wdata            = mark_rdata | (WORD_W'(1) << rel_bit);
                    n_sum[SUMW'(r_waddr)] = 1'b1;
                    n_free_cnt            = r_free_cnt + WW'(1);
                    emit                  = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            S_TRIM_RD: begin
                mark_raddr = NWA'(top_dec >> BIT_W);
                n_waddr    = NWA'(top_dec >> BIT_W);
                n_state    = S_TRIM;
            end
            S_TRIM: begin
                mark_we               = 1'b1;
                mark_wdata            = trim.word;
                n_sum[SUMW'(r_waddr)] = |trim.word;
                n_top                 = r_top - WW'(trim.run);
                n_free_cnt            = r_free_cnt - WW'(trim.run);
                if (trim.run == ({1'b0, trim_bit} + (BIT_W + 1)'(1)) && n_top != '0) begin
                    n_state = S_TRIM_RD;
                end else begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_bump) begin
            if (bump_ok) begin
                n_out_slot = r_top[SLOT_W-1:0];
                n_top      = r_top + WW'(1);
                if (r_top[BIT_W-1:0] == '0) begin
                    mark_we    = 1'b1;
                    mark_waddr = NWA'(r_top >> BIT_W);
                    mark_wdata = '0;
                end
            end else begin
                n_out_status = ST_FULL;
            end
            emit = 1'b1;
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_top   = n_top[TOP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ordered   <= 1'b1;
            r_capacity  <= CAP_W'(1024);
            r_top       <= '0;
            r_free_cnt  <= '0;
            r_depth     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_free_cnt  <= n_free_cnt;
            r_depth     <= n_depth;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ORDERED_MODE: r_ordered  <= i_cfg_data[0];
                    CFG_CAPACITY:     r_capacity <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk      <= n_chunk;
        r_waddr      <= n_waddr;
        r_slot       <= n_slot;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
        r_out_top    <= n_out_top;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_granted_slot = r_out_slot;
    assign o_status       = r_out_status;
    assign o_top_count    = r_out_top;

    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAKE |-> mark_rdata != '0)
        else $error("summary points at an empty mark word");

    a_free_le_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_top)
        else $error("free count exceeds the top");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= WW'(POOL_SLOTS))
        else $error("reuse stack overflow");

    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_FULL |-> r_out_slot == '0)
        else $error("full status carries a granted slot");

    a_pop_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> r_out_valid)
        else $error("stack pop gave no result");

endmodule
